[sv/cdbi_pkg.sv]
// Shared types, constants and payload structs of the day brightness interpolator.
package cdbi_pkg;

  localparam int DEF_MAX_ANCHORS = 16;
  localparam int DAY_MINUTES     = 1440;
  localparam int MINUTE_W        = 11;
  localparam int LEVEL_W         = 7;
  localparam int INDEX_W         = 4;
  localparam int COUNT_W         = 5;
  localparam int LEVEL_MAX       = 127;
  // Largest dividend is 127 * 1439 + 719, which fits in 18 bits.
  localparam int DIVIDEND_W      = 18;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [INDEX_W-1:0]    anchor_index;
    logic [MINUTE_W-1:0]   anchor_minute;
    logic [LEVEL_W-1:0]    anchor_level;
    logic [MINUTE_W-1:0]   query_minute;
  } query_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level_now;
    logic [MINUTE_W-1:0] next_minute;
    logic                table_empty;
  } result_item_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [LEVEL_W-1:0]  level;
  } anchor_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [MINUTE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/cdbi_chan_if.sv]
// Valid/ready channel interface carrying one payload of a given type.
interface cdbi_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/cdbi_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module cdbi_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/cdbi_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module cdbi_div
  import cdbi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [MINUTE_W-1:0]   rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [MINUTE_W-1:0]   dvs_q;

  logic [MINUTE_W:0]     rem_sh;
  logic [MINUTE_W:0]     rem_nx;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_nx[MINUTE_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[sv/circular_day_brightness_interpolator.sv]
// Top level of the circular day brightness interpolator.
//
//   Channel   Direction   Payload          Transaction
//   in_i      sink        query_item_t     load one anchor or query one minute
//   out_o     source      result_item_t    level, next anchor minute, empty flag
//   cfg_i     sink        5-bit count      write the anchor count register
//
// A load is taken in the idle state and leaves the block ready for the next transaction.
// A query against n anchors scans the anchor RAM one entry per cycle through its
// single read port, then, unless one anchor is active or the segment span is zero,
// an 18-step serial divider forms the interpolated level. An empty table skips the
// scan and goes straight to the done state.
// Reset clears the control state and the anchor count; the anchor RAM is not
// cleared. A stalled result waits in the output register while the next
// transaction is taken; a finished query waits only if that register is full.
module circular_day_brightness_interpolator
  import cdbi_pkg::*;
#(
  parameter int MAX_ANCHORS = DEF_MAX_ANCHORS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cdbi_chan_if.sink    in_i,
  cdbi_chan_if.source  out_o,
  cdbi_chan_if.sink    cfg_i
);

  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int CW = $clog2(MAX_ANCHORS + 1);

  // Folds an 11-bit minute back into the day.
  function automatic logic [MINUTE_W-1:0] fold_minute(input logic [MINUTE_W-1:0] v);
    return (v >= MINUTE_W'(DAY_MINUTES)) ? (v - MINUTE_W'(DAY_MINUTES)) : v;
  endfunction

  // Forward distance from one minute to another around the day circle.
  function automatic logic [MINUTE_W-1:0] circ_dist(input logic [MINUTE_W-1:0] from,
                                                    input logic [MINUTE_W-1:0] to);
    logic [MINUTE_W:0] d;
    d = {1'b0, to} - {1'b0, from};
    if (to < from) begin
      d = d + (MINUTE_W + 1)'(DAY_MINUTES);
    end
    return d[MINUTE_W-1:0];
  endfunction

  state_e state_q, state_d;

  query_item_t item;
  logic        in_acc;
  logic        is_query;
  logic        out_load;

  logic [COUNT_W-1:0] anchor_count_q;
  logic [CW-1:0]      n_now;
  logic [CW-1:0]      n_q;

  // Scan bookkeeping: rd_cnt_q is the next address to read, ridx_q the index
  // whose data is on the RAM output when rv_q is set.
  logic [CW-1:0] rd_cnt_q;
  logic [CW-1:0] ridx_q;
  logic          rv_q;
  logic          rd_issue;

  logic                ram_we;
  anchor_t             ram_wdata;
  anchor_t             rd_e;

  logic [MINUTE_W-1:0] q_q;
  anchor_t             e0_q;
  anchor_t             prev_q;
  anchor_t             last_q;
  anchor_t             lo_q;
  anchor_t             hi_q;
  logic                seg_found_q;
  logic [MINUTE_W-1:0] next_q;
  logic                next_found_q;
  logic                seg_hit;
  logic                next_hit;

  // Interpolation operands.
  logic                  in_range;
  logic [LEVEL_W-1:0]    op_a;
  logic [LEVEL_W-1:0]    op_b;
  logic [MINUTE_W-1:0]   op_pos;
  logic [MINUTE_W-1:0]   op_span;
  logic                  op_neg;
  logic [LEVEL_W-1:0]    op_mag;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  calc_to_div;

  logic [LEVEL_W-1:0]    a_q;
  logic                  neg_q;
  logic [LEVEL_W-1:0]    res_level_q;
  logic                  res_empty_q;
  logic [LEVEL_W-1:0]    sat_level;
  logic [DIVIDEND_W:0]   up_sum;

  div_req_t     div_req;
  div_rsp_t     div_rsp;
  result_item_t out_q;
  logic         out_valid_q;

  assign item     = in_i.data;
  assign in_acc   = in_i.valid && in_i.ready;
  assign is_query = item.opcode == OP_QUERY;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A count above the table depth behaves as the full table.
  assign n_now = (int'(anchor_count_q) > MAX_ANCHORS) ? CW'(MAX_ANCHORS)
                                                      : CW'(anchor_count_q);

  // Loads write the RAM in the cycle they are accepted; the scan only reads,
  // and no load can be taken while a scan is running.
  assign ram_we           = in_acc && !is_query && (int'(item.anchor_index) < MAX_ANCHORS);
  assign ram_wdata.minute = fold_minute(item.anchor_minute);
  assign ram_wdata.level  = item.anchor_level;

  cdbi_ram #(
    .W (MINUTE_W + LEVEL_W),
    .D (MAX_ANCHORS),
    .AW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(item.anchor_index)),
    .wdata_i(ram_wdata),
    .re_i   (rd_issue),
    .raddr_i(rd_cnt_q[AW-1:0]),
    .rdata_o(rd_e)
  );

  // The first segment whose start is at or before the query and whose end
  // lies after it wins, as does the first anchor strictly after the query.
  assign seg_hit  = rv_q && (ridx_q != '0) && !seg_found_q &&
                    (prev_q.minute <= q_q) && (q_q < rd_e.minute);
  assign next_hit = rv_q && !next_found_q && (rd_e.minute > q_q);

  // Queries between the first and last anchor use the segment found by the
  // scan; all others use the wrap segment from the last anchor to the first.
  always_comb begin
    in_range = (q_q >= e0_q.minute) && (q_q < last_q.minute);
    if (in_range) begin
      op_a    = lo_q.level;
      op_b    = hi_q.level;
      op_pos  = q_q - lo_q.minute;
      op_span = hi_q.minute - lo_q.minute;
    end else begin
      op_a    = last_q.level;
      op_b    = e0_q.level;
      op_pos  = circ_dist(last_q.minute, q_q);
      op_span = circ_dist(last_q.minute, e0_q.minute);
    end
    op_neg   = op_b < op_a;
    op_mag   = op_neg ? (op_a - op_b) : (op_b - op_a);
    // Magnitude of diff * pos plus half the span; the sign is applied after
    // the divide, which gives rounding half away from zero.
    dividend = DIVIDEND_W'(op_mag) * DIVIDEND_W'(op_pos) + DIVIDEND_W'(op_span >> 1);
  end

  assign div_req.start    = calc_to_div;
  assign div_req.dividend = dividend;
  assign div_req.divisor  = op_span;

  cdbi_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Apply the sign of the slope and clamp to the 7-bit level range.
  always_comb begin
    up_sum = {{(DIVIDEND_W + 1 - LEVEL_W){1'b0}}, a_q} + {1'b0, div_rsp.quotient};
    if (neg_q) begin
      sat_level = (div_rsp.quotient > DIVIDEND_W'(a_q)) ? '0
                  : (a_q - div_rsp.quotient[LEVEL_W-1:0]);
    end else begin
      sat_level = (up_sum > (DIVIDEND_W + 1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                  : up_sum[LEVEL_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_issue    = 1'b0;
    calc_to_div = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (n_now == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = rd_cnt_q < n_q;
        if (rv_q && (ridx_q == n_q - CW'(1))) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if ((n_q == CW'(1)) || (op_span == '0)) begin
          state_d = ST_DONE;
        end else begin
          calc_to_div = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      anchor_count_q <= '0;
      rd_cnt_q       <= '0;
      rv_q           <= 1'b0;
      seg_found_q    <= 1'b0;
      next_found_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        anchor_count_q <= cfg_i.data;
      end
      if (state_q == ST_IDLE) begin
        rd_cnt_q     <= '0;
        rv_q         <= 1'b0;
        seg_found_q  <= 1'b0;
        next_found_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (rd_issue) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        rv_q <= rd_issue;
        if (seg_hit) begin
          seg_found_q <= 1'b1;
        end
        if (next_hit) begin
          next_found_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          q_q         <= fold_minute(item.query_minute);
          n_q         <= n_now;
          res_empty_q <= n_now == '0;
          res_level_q <= '0;
        end
      end
      ST_SCAN: begin
        ridx_q <= rd_cnt_q;
        if (rv_q) begin
          if (ridx_q == '0) begin
            e0_q <= rd_e;
          end
          prev_q <= rd_e;
          last_q <= rd_e;
          if (seg_hit) begin
            lo_q <= prev_q;
            hi_q <= rd_e;
          end
          if (next_hit) begin
            next_q <= rd_e.minute;
          end
        end
      end
      ST_CALC: begin
        if (n_q == CW'(1)) begin
          res_level_q <= e0_q.level;
        end else if (op_span == '0) begin
          res_level_q <= op_a;
        end else begin
          a_q   <= op_a;
          neg_q <= op_neg;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_level_q <= sat_level;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_q.level_now   <= res_level_q;
          out_q.table_empty <= res_empty_q;
          if (res_empty_q) begin
            out_q.next_minute <= '0;
          end else begin
            out_q.next_minute <= next_found_q ? next_q : e0_q.minute;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/cdbi_chk.sv]
// Port-level assertions for the interpolator, bound to the top level.
module cdbi_chk
  import cdbi_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input opcode_e      in_opcode_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input result_item_t out_data_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // A query occupies the block, so no transaction is taken right after it.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_QUERY) |=> !in_ready_i)
    else $error("input taken right after a query");

  // A load finishes in its own cycle and leaves the input open.
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OP_LOAD) |=> in_ready_i)
    else $error("input closed after a load");

endmodule

bind circular_day_brightness_interpolator cdbi_chk u_cdbi_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_opcode_i(in_i.data.opcode),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

[sim/circular_day_brightness_interpolator_test.sv]
// Self-checking testbench for the circular day brightness interpolator.
module circular_day_brightness_interpolator_test;
  import cdbi_pkg::*;

  localparam int ITEM_TARGET   = 1350;
  // Settling wait, sized to cover a query against a full table.
  localparam int QUERY_LATENCY = 48;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst_n;

  cdbi_chan_if #(.T(query_item_t))          in_ch ();
  cdbi_chan_if #(.T(result_item_t))         out_ch ();
  cdbi_chan_if #(.T(logic [COUNT_W-1:0]))   cfg_ch ();

  circular_day_brightness_interpolator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the anchor table and count register, updated on each accepted load and count write.
  logic [MINUTE_W-1:0] shadow_minute [DEF_MAX_ANCHORS];
  logic [LEVEL_W-1:0]  shadow_level  [DEF_MAX_ANCHORS];
  logic [COUNT_W-1:0]  shadow_count;
  result_item_t        pending_answers [$];

  int items_sent   = 0;
  int fail_count   = 0;
  int report_count = 0;
  int cycle_count  = 0;
  int gap_odds     = 3;
  int stall_odds   = 3;
  bit calm         = 1'b0;

  function automatic int fold_minute(logic [MINUTE_W-1:0] m);
    return (int'(m) >= DAY_MINUTES) ? int'(m) - DAY_MINUTES : int'(m);
  endfunction

  function automatic int circle_gap(int from, int to);
    int d;
    d = to - from;
    if (d < 0) d += DAY_MINUTES;
    return d;
  endfunction

  // Linear blend from a to b, rounded half away from zero with truncating division.
  function automatic int blend(int a, int b, int pos, int span);
    int diff;
    int half;
    if (span <= 0) return a;
    diff = b - a;
    half = span / 2;
    if (diff < 0) half = -half;
    return a + (diff * pos + half) / span;
  endfunction

  function automatic result_item_t answer_query(logic [MINUTE_W-1:0] raw_minute);
    result_item_t r;
    int n, q, last, lvl, nxt;
    bit found;
    r = '0;
    n = (int'(shadow_count) > DEF_MAX_ANCHORS) ? DEF_MAX_ANCHORS : int'(shadow_count);
    if (n == 0) begin
      r.table_empty = 1'b1;
      return r;
    end
    q = fold_minute(raw_minute);
    last = n - 1;
    found = 1'b0;
    if (n == 1) begin
      lvl = int'(shadow_level[0]);
      found = 1'b1;
    end else if (q >= int'(shadow_minute[0]) && q < int'(shadow_minute[last])) begin
      for (int i = 0; i < last && !found; i++) begin
        if (q >= int'(shadow_minute[i]) && q < int'(shadow_minute[i+1])) begin
          lvl = blend(int'(shadow_level[i]), int'(shadow_level[i+1]),
                      q - int'(shadow_minute[i]),
                      int'(shadow_minute[i+1]) - int'(shadow_minute[i]));
          found = 1'b1;
        end
      end
    end
    // Anything outside the first-to-last range takes the segment across midnight.
    if (!found)
      lvl = blend(int'(shadow_level[last]), int'(shadow_level[0]),
                  circle_gap(int'(shadow_minute[last]), q),
                  circle_gap(int'(shadow_minute[last]), int'(shadow_minute[0])));
    if (lvl < 0) lvl = 0;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    nxt = int'(shadow_minute[0]);
    found = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      if (int'(shadow_minute[i]) > q) begin
        nxt = int'(shadow_minute[i]);
        found = 1'b1;
      end
    end
    r.level_now   = LEVEL_W'(lvl);
    r.next_minute = MINUTE_W'(nxt);
    return r;
  endfunction

  task automatic note_failure(string what, logic [MINUTE_W-1:0] want, logic [MINUTE_W-1:0] got);
    fail_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // One transaction on the input channel; the mirror is updated at acceptance.
  task automatic send_item(query_item_t item);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (item.opcode == OP_LOAD) begin
      shadow_minute[item.anchor_index] = MINUTE_W'(fold_minute(item.anchor_minute));
      shadow_level[item.anchor_index]  = item.anchor_level;
    end else begin
      pending_answers.push_back(answer_query(item.query_minute));
    end
  endtask

  // Load fields carry junk query minutes and vice versa; the block must ignore them.
  task automatic send_load(int idx, int minute, int level);
    query_item_t item;
    item.opcode        = OP_LOAD;
    item.anchor_index  = INDEX_W'(idx);
    item.anchor_minute = MINUTE_W'(minute);
    item.anchor_level  = LEVEL_W'(level);
    item.query_minute  = MINUTE_W'($urandom);
    send_item(item);
  endtask

  task automatic send_query(int minute);
    query_item_t item;
    item.opcode        = OP_QUERY;
    item.anchor_index  = INDEX_W'($urandom);
    item.anchor_minute = MINUTE_W'($urandom);
    item.anchor_level  = LEVEL_W'($urandom);
    item.query_minute  = MINUTE_W'(minute);
    send_item(item);
  endtask

  // Drains every outstanding query so that the count register may be written.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (QUERY_LATENCY) @(posedge clk);
  endtask

  task automatic write_count(int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= COUNT_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_count = COUNT_W'(value);
  endtask

  // Writes all sixteen entries in minute order, either spread over the day or
  // packed into a narrow window so that equal minutes and zero spans appear.
  task automatic load_sorted_table(bit clustered);
    int mins [$];
    int base;
    int m;
    base = $urandom_range(0, DAY_MINUTES - 21);
    for (int i = 0; i < DEF_MAX_ANCHORS; i++)
      mins.push_back(clustered ? base + $urandom_range(0, 20) : $urandom_range(0, DAY_MINUTES - 1));
    mins.sort();
    for (int i = 0; i < DEF_MAX_ANCHORS; i++) begin
      // The alias one day later folds back onto the same minute.
      m = (mins[i] < 2048 - DAY_MINUTES && $urandom_range(0, 3) == 0) ? mins[i] + DAY_MINUTES
                                                                        : mins[i];
      send_load(i, m, ($urandom_range(0, 9) == 0) ? $urandom_range(0, LEVEL_MAX)
                                                    : $urandom_range(0, 100));
    end
  endtask

  task automatic test_empty_table();
    send_query(0);
    send_query(2047);
  endtask

  task automatic test_single_anchor();
    send_load(0, 2047, 100);
    settle();
    write_count(1);
    send_query(0);
    send_query(607);
    send_query(1439);
  endtask

  // Two anchors on the same minute: the wrap segment has no length.
  task automatic test_zero_span();
    send_load(1, 607, 20);
    settle();
    write_count(2);
    send_query(607);
    send_query(0);
  endtask

  task automatic test_rounding_and_wrap();
    send_load(0, 0, 0);
    send_load(1, 2, 1);
    send_load(2, 6, 0);
    settle();
    write_count(3);
    send_query(1);
    send_query(4);
    send_query(1000);
  endtask

  // Out-of-order anchors push the wrap blend far beyond the level range.
  task automatic test_unsorted_saturation();
    send_load(0, 100, LEVEL_MAX);
    send_load(1, 50, 0);
    settle();
    write_count(2);
    send_query(40);
    send_load(0, 100, 0);
    send_load(1, 50, LEVEL_MAX);
    send_query(40);
    send_query(75);
  endtask

  task automatic test_count_limits();
    load_sorted_table(1'b0);
    settle();
    write_count(DEF_MAX_ANCHORS);
    send_query(0);
    send_query(1439);
    send_query(2047);
    settle();
    write_count(31);
    send_query(720);
    settle();
    write_count(0);
    send_query(720);
  endtask

  task automatic test_random_tables();
    int pick;
    int n;
    int rounds;
    while (items_sent < ITEM_TARGET) begin
      calm       = (items_sent >= ITEM_TARGET - 200);
      gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      load_sorted_table($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      case (pick)
        0:       n = 0;
        1:       n = 1;
        2:       n = DEF_MAX_ANCHORS;
        3:       n = $urandom_range(DEF_MAX_ANCHORS + 1, 31);
        default: n = $urandom_range(2, DEF_MAX_ANCHORS);
      endcase
      settle();
      write_count(n);
      rounds = $urandom_range(20, 60);
      repeat (rounds) begin
        pick = $urandom_range(0, 19);
        if (pick < 4) begin
          // Loads mostly land outside the active range, which keeps the table sorted.
          if (n < DEF_MAX_ANCHORS && pick < 3)
            send_load($urandom_range(n, DEF_MAX_ANCHORS - 1), $urandom_range(0, 2047),
                      $urandom_range(0, LEVEL_MAX));
          else
            send_load($urandom_range(0, DEF_MAX_ANCHORS - 1), $urandom_range(0, 2047),
                      $urandom_range(0, LEVEL_MAX));
        end else if (pick < 9) begin
          // Right at, just before and just after an anchor.
          send_query(int'(shadow_minute[$urandom_range(0, DEF_MAX_ANCHORS - 1)]) +
                     int'($urandom_range(0, 2)) - 1);
        end else if (pick < 11) begin
          send_query($urandom_range(0, 2047));
        end else begin
          send_query($urandom_range(0, DAY_MINUTES - 1));
        end
      end
    end
  endtask

  // Result side: random back-pressure bursts, none once the run turns calm.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        note_failure("result with no query outstanding", '0, out_ch.data.next_minute);
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.data.level_now !== want.level_now)
          note_failure("level_now", MINUTE_W'(want.level_now),
                       MINUTE_W'(out_ch.data.level_now));
        if (out_ch.data.next_minute !== want.next_minute)
          note_failure("next_minute", want.next_minute, out_ch.data.next_minute);
        if (out_ch.data.table_empty !== want.table_empty)
          note_failure("table_empty", MINUTE_W'(want.table_empty),
                       MINUTE_W'(out_ch.data.table_empty));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    shadow_count = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_single_anchor();
    test_zero_span();
    test_rounding_and_wrap();
    test_unsorted_saturation();
    test_count_limits();
    test_random_tables();

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/cdbi_pkg.sv
sv/cdbi_chan_if.sv
sv/cdbi_ram.sv
sv/cdbi_div.sv
sv/circular_day_brightness_interpolator.sv
sv/cdbi_chk.sv
sim/circular_day_brightness_interpolator_test.sv
